// ===== hw/rtl/clipped_scaled_rect_blitter_core_macros.svh =====
// Assertion macros shared by the blitter RTL.
// Included by the top level only; it needs nothing else.
`ifndef CLIPPED_SCALED_RECT_BLITTER_CORE_MACROS_SVH
`define CLIPPED_SCALED_RECT_BLITTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blitter check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blitter check failed");

`endif

// ===== hw/rtl/csrb_pkg.sv =====
// Shared types and constants of the clipped, scaled rectangle blitter.
// No dependencies; the front end, queue, write generator and top level use it.
package csrb_pkg;

	localparam int unsigned DISP_WIDTH_DEF  = 1024;
	localparam int unsigned DISP_HEIGHT_DEF = 1024;
	localparam int unsigned MAX_SCALE_DEF   = 8;

	localparam int unsigned COL_W      = 10;
	localparam int unsigned DIM_W      = 11;
	localparam int unsigned MAX_DIM    = 1024;
	localparam int unsigned SCALE_W    = 4;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned COORD_W    = 15;
	localparam int unsigned IDX_W      = 20;
	localparam int unsigned COLOR_W    = 32;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SRC_WIDTH     = 3'd2,
		REG_SRC_HEIGHT    = 3'd3,
		REG_SCALE_FACTOR  = 3'd4,
		REG_INPUT_MODE    = 3'd5,
		REG_OUTPUT_FORMAT = 3'd6
	} reg_idx_t;

	localparam logic [MODE_W-1:0] MODE_TRANSPARENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SIGNED      = 2'd2;
	localparam logic              FMT_XRGB32       = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [IDX_W-1:0]   write_index;
		logic [COLOR_W-1:0] write_color;
		logic               last_write;
	} wr_t;

	// One kept source pixel, ready to be replicated.
	typedef struct packed {
		logic [IDX_W-1:0]   base;
		logic [COLOR_W-1:0] color;
		logic [SCALE_W-1:0] scale;
	} cmd_t;

endpackage

// ===== hw/rtl/csrb_stream_if.sv =====
// Valid/ready stream channel carrying one payload item.
// The payload type is set per instance; depends on nothing.
interface csrb_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/csrb_front.sv =====
// Front end: configuration registers, source position counters, clipping and
// color conversion. Emits one command per kept pixel. Uses csrb_pkg and csrb_stream_if.
module csrb_front #(
	parameter int unsigned DISP_WIDTH  = csrb_pkg::DISP_WIDTH_DEF,
	parameter int unsigned DISP_HEIGHT = csrb_pkg::DISP_HEIGHT_DEF,
	parameter int unsigned MAX_SCALE   = csrb_pkg::MAX_SCALE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csrb_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [csrb_pkg::CFG_DATA_W-1:0]     cfg_data,
	csrb_stream_if.sink                         pix,
	output logic                                push,
	output csrb_pkg::cmd_t                      push_cmd,
	input  logic                                q_full
);
	localparam int unsigned CW   = csrb_pkg::COORD_W;
	localparam int unsigned DW_W = $clog2(DISP_WIDTH + 1);
	localparam int unsigned PW   = CW + DW_W;

	logic [csrb_pkg::COL_W-1:0]   dest_x_q, dest_y_q;
	logic [csrb_pkg::DIM_W-1:0]   src_width_q, src_height_q;
	logic [csrb_pkg::SCALE_W-1:0] scale_q;
	logic [csrb_pkg::MODE_W-1:0]  mode_q;
	logic                         fmt_q;
	logic [csrb_pkg::COL_W-1:0]   col_q, row_q;

	logic [csrb_pkg::DIM_W-1:0]   width_eff, height_eff;
	logic [csrb_pkg::SCALE_W-1:0] scale_eff;
	logic [CW-1:0]                x0, y0;
	logic                         in_range, transp, accept;
	logic [csrb_pkg::CHAN_W-1:0]  r, g, b;
	logic [csrb_pkg::COLOR_W-1:0] color;

	logic                         valid_s1, pass_s1;
	logic [CW-1:0]                x0_s1, y0_s1;
	logic [csrb_pkg::COLOR_W-1:0] color_s1;
	logic [csrb_pkg::SCALE_W-1:0] scale_s1;

	logic                         keep, s1_free;
	logic [CW:0]                  x_end, y_end;
	logic [PW-1:0]                row_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q     <= '0;
			dest_y_q     <= '0;
			src_width_q  <= csrb_pkg::DIM_W'(1);
			src_height_q <= csrb_pkg::DIM_W'(1);
			scale_q      <= csrb_pkg::SCALE_W'(1);
			mode_q       <= '0;
			fmt_q        <= 1'b0;
		end else if (cfg_we) begin
			case (csrb_pkg::reg_idx_t'(cfg_index))
				csrb_pkg::REG_DEST_X:        dest_x_q     <= cfg_data[csrb_pkg::COL_W-1:0];
				csrb_pkg::REG_DEST_Y:        dest_y_q     <= cfg_data[csrb_pkg::COL_W-1:0];
				csrb_pkg::REG_SRC_WIDTH:     src_width_q  <= cfg_data;
				csrb_pkg::REG_SRC_HEIGHT:    src_height_q <= cfg_data;
				csrb_pkg::REG_SCALE_FACTOR:  scale_q      <= cfg_data[csrb_pkg::SCALE_W-1:0];
				csrb_pkg::REG_INPUT_MODE:    mode_q       <= cfg_data[csrb_pkg::MODE_W-1:0];
				csrb_pkg::REG_OUTPUT_FORMAT: fmt_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_width_q == '0)
			width_eff = csrb_pkg::DIM_W'(1);
		else if (src_width_q > csrb_pkg::DIM_W'(csrb_pkg::MAX_DIM))
			width_eff = csrb_pkg::DIM_W'(csrb_pkg::MAX_DIM);
		else
			width_eff = src_width_q;
		if (src_height_q == '0)
			height_eff = csrb_pkg::DIM_W'(1);
		else if (src_height_q > csrb_pkg::DIM_W'(csrb_pkg::MAX_DIM))
			height_eff = csrb_pkg::DIM_W'(csrb_pkg::MAX_DIM);
		else
			height_eff = src_height_q;
		if (scale_q == '0)
			scale_eff = csrb_pkg::SCALE_W'(1);
		else if (scale_q > csrb_pkg::SCALE_W'(MAX_SCALE))
			scale_eff = csrb_pkg::SCALE_W'(MAX_SCALE);
		else
			scale_eff = scale_q;
	end

	assign x0 = CW'(dest_x_q) + CW'(col_q) * CW'(scale_eff);
	assign y0 = CW'(dest_y_q) + CW'(row_q) * CW'(scale_eff);
	assign in_range = ({1'b0, col_q} < width_eff) && ({1'b0, row_q} < height_eff);
	assign transp = (mode_q == csrb_pkg::MODE_TRANSPARENT) &&
		(pix.data.red_in == '0) && (pix.data.green_in == '0) && (pix.data.blue_in == '0);

	// Signed bytes are offset by flipping the sign bit; RGB565 swaps red and blue
	// for the unsigned modes only.
	always_comb begin
		r = pix.data.red_in;
		g = pix.data.green_in;
		b = pix.data.blue_in;
		if (mode_q == csrb_pkg::MODE_SIGNED) begin
			r = r ^ 8'h80;
			g = g ^ 8'h80;
			b = b ^ 8'h80;
			if (fmt_q == csrb_pkg::FMT_XRGB32)
				color = {8'h00, r, g, b};
			else
				color = {16'h0000, r[7:3], g[7:2], b[7:3]};
		end else if (fmt_q == csrb_pkg::FMT_XRGB32) begin
			color = {8'h00, r, g, b};
		end else begin
			color = {16'h0000, b[7:3], g[7:2], r[7:3]};
		end
	end

	// A block is kept only when it lies wholly on the display; an origin off the
	// display always fails this test as well.
	assign x_end = {1'b0, x0_s1} + (CW+1)'(scale_s1);
	assign y_end = {1'b0, y0_s1} + (CW+1)'(scale_s1);
	assign keep  = pass_s1 && (x_end <= (CW+1)'(DISP_WIDTH)) &&
		(y_end <= (CW+1)'(DISP_HEIGHT));
	assign row_prod = PW'(y0_s1) * PW'(DISP_WIDTH);

	assign push_cmd.base  = row_prod[csrb_pkg::IDX_W-1:0] + csrb_pkg::IDX_W'(x0_s1);
	assign push_cmd.color = color_s1;
	assign push_cmd.scale = scale_s1;
	assign push          = valid_s1 && keep && !q_full;

	assign s1_free   = !valid_s1 || !keep || !q_full;
	assign pix.ready = s1_free;
	assign accept    = pix.valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if ({1'b0, col_q} + csrb_pkg::DIM_W'(1) >= width_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + csrb_pkg::DIM_W'(1) >= height_eff)
					row_q <= '0;
				else
					row_q <= row_q + csrb_pkg::COL_W'(1);
			end else begin
				col_q <= col_q + csrb_pkg::COL_W'(1);
			end
		end else if (s1_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_s1    <= x0;
			y0_s1    <= y0;
			pass_s1  <= in_range && !transp;
			color_s1 <= color;
			scale_s1 <= scale_eff;
		end
	end

endmodule

// ===== hw/rtl/csrb_queue.sv =====
// Two-entry command queue between the front end and the write generator.
// Uses csrb_pkg for the command type.
module csrb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csrb_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output csrb_pkg::cmd_t head
);
	csrb_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== hw/rtl/csrb_back.sv =====
// Write generator: replicates the queue head over its scale by scale block,
// row by row, into a registered output. Uses csrb_pkg and csrb_stream_if.
module csrb_back #(
	parameter int unsigned DISP_WIDTH = csrb_pkg::DISP_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  csrb_pkg::cmd_t head,
	output logic           pop,
	csrb_stream_if.source  wr
);
	localparam int unsigned IW = csrb_pkg::IDX_W;

	logic [csrb_pkg::SCALE_W-1:0] kx_q, ky_q, s_last;
	logic [IW-1:0]                off_q, row_step;
	logic                         emit, col_end, blk_end;
	logic                         out_valid_q;
	csrb_pkg::wr_t                out_q;

	assign s_last   = head.scale - csrb_pkg::SCALE_W'(1);
	assign col_end  = (kx_q == s_last);
	assign blk_end  = col_end && (ky_q == s_last);
	// From the last column of one row to the first column of the next.
	assign row_step = IW'(DISP_WIDTH) - IW'(head.scale) + IW'(1);
	assign emit     = head_valid && (!out_valid_q || wr.ready);
	assign pop      = emit && blk_end;

	assign wr.valid = out_valid_q;
	assign wr.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_q        <= '0;
			ky_q        <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (blk_end) begin
					kx_q  <= '0;
					ky_q  <= '0;
					off_q <= '0;
				end else if (col_end) begin
					kx_q  <= '0;
					ky_q  <= ky_q + csrb_pkg::SCALE_W'(1);
					off_q <= off_q + row_step;
				end else begin
					kx_q  <= kx_q + csrb_pkg::SCALE_W'(1);
					off_q <= off_q + IW'(1);
				end
			end else if (wr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.write_index <= head.base + off_q;
			out_q.write_color <= head.color;
			out_q.last_write  <= blk_end;
		end
	end

endmodule

// ===== hw/rtl/clipped_scaled_rect_blitter_core.sv =====
// Clipped, scaled rectangle blitter. A pixel passes the stage-1 register and the
// queue to the output register. Throughput: one write per cycle while the output
// is ready; a kept pixel gives scale^2 writes from the write generator's block
// counters, so at scale one a pixel is taken every cycle, as is a dropped pixel.
// Reset (arst_n low, asynchronous) clears the counters and the queue, empties
// the output and returns the registers to their defaults.
`include "clipped_scaled_rect_blitter_core_macros.svh"
module clipped_scaled_rect_blitter_core #(
	parameter int unsigned DISP_WIDTH  = csrb_pkg::DISP_WIDTH_DEF,
	parameter int unsigned DISP_HEIGHT = csrb_pkg::DISP_HEIGHT_DEF,
	parameter int unsigned MAX_SCALE   = csrb_pkg::MAX_SCALE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csrb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [csrb_pkg::CFG_DATA_W-1:0] cfg_data,
	csrb_stream_if.sink                     pix,
	csrb_stream_if.source                   wr
);
	logic           q_push, q_full, q_pop, q_valid;
	csrb_pkg::cmd_t q_in, q_head;

	csrb_front #(
		.DISP_WIDTH (DISP_WIDTH),
		.DISP_HEIGHT(DISP_HEIGHT),
		.MAX_SCALE  (MAX_SCALE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix),
		.push     (q_push),
		.push_cmd (q_in),
		.q_full   (q_full)
	);

	csrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (q_head)
	);

	csrb_back #(
		.DISP_WIDTH(DISP_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head      (q_head),
		.pop       (q_pop),
		.wr        (wr)
	);

	`CSRB_ASSERT_IMPL(a_push_room, clk, arst_n, q_push, !q_full)
	`CSRB_ASSERT_IMPL(a_pop_head, clk, arst_n, q_pop, q_valid)
	`CSRB_ASSERT_NEXT(a_pop_last, clk, arst_n, q_pop, wr.valid && wr.data.last_write)

endmodule
